/* sv/vag_pkg.sv */
// Shared types and constants for the vector autoregression generator.
// Beat structs, operation codes, register indexes, controller/datapath bundles.
// No dependencies.
`default_nettype none

package vag_pkg;

  localparam int STRIDE     = 8;
  localparam int CH_W       = 3;
  localparam int LAG_FW     = 3;
  localparam int IDX_W      = 8;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CNT_W      = 4;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_LAGS_DEF     = 4;

  localparam logic [1:0] OP_COEF = 2'd0;
  localparam logic [1:0] OP_ICPT = 2'd1;
  localparam logic [1:0] OP_HIST = 2'd2;
  localparam logic [1:0] OP_STEP = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAGS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ICPT     = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] sample;
    logic                     last_of_step;
  } out_beat_t;

  typedef struct packed {
    logic              load;
    logic              start;
    logic              term;
    logic              hist_rd;
    logic              hist_wr;
    logic              row0_wr;
    logic              emit;
    logic              last;
    logic [LAG_FW-1:0] lag;
    logic [CH_W-1:0]   chan;
    logic [CH_W-1:0]   ch;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/vag_datapath.sv */
// Datapath: coefficient and history memories, intercept and pending rows,
// pipelined multiply-accumulate, saturation and the output register.
// Depends on vag_pkg.
`default_nettype none

module vag_datapath #(
  parameter int MAX_LAGS = vag_pkg::MAX_LAGS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  vag_pkg::dp_cmd_t     cmd,
  input  vag_pkg::in_beat_t    in_data,
  input  wire                  use_intercept,
  output vag_pkg::dp_status_t  status,
  output logic                 out_valid,
  input  wire                  out_stall,
  output vag_pkg::out_beat_t   out_data
);
  import vag_pkg::*;

  localparam int LAG_W      = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam int HA_W       = LAG_W + CH_W;
  localparam int HIST_DEPTH = 1 << HA_W;

  logic signed [DATA_W-1:0] coef_mem [0:255];
  logic signed [DATA_W-1:0] hist_mem [0:HIST_DEPTH-1];
  logic signed [DATA_W-1:0] icpt_r   [0:STRIDE-1];
  logic signed [DATA_W-1:0] pend_r   [0:STRIDE-1];

  logic signed [DATA_W-1:0] coef_q_r, hist_q_r;
  logic signed [ACC_W-1:0]  prod_r, acc_r, acc_nxt;
  logic                     vld1_r, vld2_r;
  logic                     out_valid_r;
  out_beat_t                out_r;

  logic                     coef_we, icpt_we, hist_we;
  logic [HA_W-1:0]          hist_waddr, hist_raddr;
  logic signed [DATA_W-1:0] hist_wdata;
  logic [7:0]               coef_raddr;
  logic signed [ACC_W-1:0]  icpt_term, res_term;

  function automatic logic [DATA_W-1:0] saturate(input logic [ACC_W-1:0] a);
    logic hi_ones, hi_zeros;
    hi_ones  = &a[ACC_W-1:ACC_W-FRAC_W-1];
    hi_zeros = ~|a[ACC_W-1:ACC_W-FRAC_W-1];
    if (hi_ones || hi_zeros) begin
      saturate = a[DATA_W+FRAC_W-1:FRAC_W];
    end else if (a[ACC_W-1]) begin
      saturate = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      saturate = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  assign coef_we = cmd.load && (in_data.operation == OP_COEF) &&
                   (32'(in_data.index[7:6]) < MAX_LAGS);
  assign icpt_we = cmd.load && (in_data.operation == OP_ICPT) &&
                   (in_data.index[7:3] == 5'd0);

  assign coef_raddr = {cmd.lag[1:0], cmd.chan, cmd.ch};
  assign hist_raddr = {LAG_W'(cmd.lag), cmd.chan};

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {LAG_W'(cmd.lag), cmd.chan};
    hist_wdata = hist_q_r;
    if (cmd.load && (in_data.operation == OP_HIST) &&
        (32'(in_data.index[7:3]) < MAX_LAGS)) begin
      hist_we    = 1'b1;
      hist_waddr = in_data.index[HA_W-1:0];
      hist_wdata = in_data.value;
    end else if (cmd.hist_wr) begin
      hist_we = 1'b1;
    end else if (cmd.row0_wr) begin
      hist_we    = 1'b1;
      hist_waddr = {LAG_W'(0), cmd.chan};
      hist_wdata = pend_r[cmd.chan];
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[in_data.index] <= in_data.value;
    end
    if (cmd.term) begin
      coef_q_r <= coef_mem[coef_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (cmd.term || cmd.hist_rd) begin
      hist_q_r <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (icpt_we) begin
      icpt_r[in_data.index[CH_W-1:0]] <= in_data.value;
    end
    if (cmd.emit) begin
      pend_r[cmd.ch] <= saturate(acc_r);
    end
  end

  assign icpt_term = use_intercept ?
                     {{FRAC_W{icpt_r[cmd.ch][DATA_W-1]}}, icpt_r[cmd.ch], {FRAC_W{1'b0}}} :
                     '0;
  assign res_term  = {{FRAC_W{in_data.value[DATA_W-1]}}, in_data.value, {FRAC_W{1'b0}}};

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start) begin
      acc_nxt = icpt_term + res_term;
    end else if (vld2_r) begin
      acc_nxt = acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (vld1_r) begin
      prod_r <= ACC_W'(coef_q_r) * ACC_W'(hist_q_r);
    end
    if (cmd.emit) begin
      out_r.channel      <= cmd.ch;
      out_r.sample       <= saturate(acc_r);
      out_r.last_of_step <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r <= cmd.term;
      vld2_r <= vld1_r;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.pipe_busy = vld1_r || vld2_r;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

`default_nettype wire

/* sv/vag_ctrl.sv */
// Controller: sequences loads, the multiply-accumulate sweep, result hand-off
// and the history shift at the end of each row. Depends on vag_pkg.
`default_nettype none

module vag_ctrl #(
  parameter int MAX_LAGS = vag_pkg::MAX_LAGS_DEF,
  parameter int PW       = $clog2(MAX_LAGS + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  wire [1:0]                in_op,
  input  wire [vag_pkg::CNT_W-1:0] n_eff,
  input  wire [PW-1:0]             p_eff,
  input  vag_pkg::dp_status_t      status,
  output logic                     in_stall,
  output vag_pkg::dp_cmd_t         cmd
);
  import vag_pkg::*;

  localparam int LAG_W = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MAC      = 7'b0000010,
    S_DRAIN    = 7'b0000100,
    S_EMIT     = 7'b0001000,
    S_SHIFT_RD = 7'b0010000,
    S_SHIFT_WR = 7'b0100000,
    S_ROW0     = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [LAG_W-1:0] lag_r, lag_nxt;
  logic [CH_W-1:0]  chan_r, chan_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [CH_W-1:0]  next_ch_r, next_ch_nxt;

  logic [CH_W-1:0]  ch_sel, n_last;
  logic [LAG_W-1:0] p_last;
  logic             accept, is_last;

  assign accept  = in_valid && (state_r == S_IDLE);
  assign ch_sel  = ({1'b0, next_ch_r} >= n_eff) ? '0 : next_ch_r;
  assign n_last  = CH_W'(n_eff - CNT_W'(1));
  assign p_last  = LAG_W'(p_eff - PW'(1));
  assign is_last = (ch_r == n_last);

  always_comb begin
    state_nxt   = state_r;
    lag_nxt     = lag_r;
    chan_nxt    = chan_r;
    ch_nxt      = ch_r;
    next_ch_nxt = next_ch_r;
    cmd         = '0;
    cmd.lag     = LAG_FW'(lag_r);
    cmd.chan    = chan_r;
    cmd.ch      = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_STEP) begin
            cmd.start = 1'b1;
            cmd.ch    = ch_sel;
            ch_nxt    = ch_sel;
            lag_nxt   = '0;
            chan_nxt  = '0;
            state_nxt = S_MAC;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_MAC: begin
        cmd.term = 1'b1;
        if (chan_r == n_last) begin
          chan_nxt = '0;
          if (lag_r == p_last) begin
            state_nxt = S_DRAIN;
          end else begin
            lag_nxt = lag_r + LAG_W'(1);
          end
        end else begin
          chan_nxt = chan_r + CH_W'(1);
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = is_last;
          if (is_last) begin
            next_ch_nxt = '0;
            chan_nxt    = '0;
            if (p_eff != PW'(1)) begin
              lag_nxt   = p_last;
              state_nxt = S_SHIFT_RD;
            end else begin
              state_nxt = S_ROW0;
            end
          end else begin
            next_ch_nxt = ch_r + CH_W'(1);
            state_nxt   = S_IDLE;
          end
        end
      end
      S_SHIFT_RD: begin
        cmd.hist_rd = 1'b1;
        cmd.lag     = LAG_FW'(lag_r - LAG_W'(1));
        state_nxt   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.hist_wr = 1'b1;
        state_nxt   = S_SHIFT_RD;
        if (chan_r == n_last) begin
          chan_nxt = '0;
          if (lag_r == LAG_W'(1)) begin
            state_nxt = S_ROW0;
          end else begin
            lag_nxt = lag_r - LAG_W'(1);
          end
        end else begin
          chan_nxt = chan_r + CH_W'(1);
        end
      end
      S_ROW0: begin
        cmd.row0_wr = 1'b1;
        if (chan_r == n_last) begin
          chan_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          chan_nxt = chan_r + CH_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lag_r     <= '0;
      chan_r    <= '0;
      ch_r      <= '0;
      next_ch_r <= '0;
    end else begin
      state_r   <= state_nxt;
      lag_r     <= lag_nxt;
      chan_r    <= chan_nxt;
      ch_r      <= ch_nxt;
      next_ch_r <= next_ch_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* sv/vector_autoregression_generator.sv */
// Top level of the VAR(p) sample generator: configuration registers,
// controller and datapath. Depends on vag_pkg, vag_ctrl, vag_datapath.
//
//   port group | dir | beat / meaning
//   in_*       | in  | in_beat_t: load coefficient/intercept/history, or step
//   out_*      | out | out_beat_t: one generated sample per step
//   cfg_*      | in  | register write: channel_count, lag_count, use_intercept
//
// A load beat does not stall the input. A step beat runs on the single shared
// multiply-accumulate (one term a cycle, three pipeline stages, then an emit
// that waits until the output register is free) and stalls the input until done.
// The last channel of a row adds a history shift through the one history
// memory port: a read and a write per channel for each lag above 0, then a
// row-0 write per channel. Reset (rst_n low, synchronous) clears
// control only; stores hold garbage until loaded. A stalled output holds one
// beat while the next step may already compute.
`default_nettype none

module vector_autoregression_generator #(
  parameter int MAX_CHANNELS = vag_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_LAGS     = vag_pkg::MAX_LAGS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  vag_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output vag_pkg::out_beat_t            out_data,
  input  wire                           cfg_we,
  input  wire [vag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [vag_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vag_pkg::*;

  localparam int CH_LIM = (MAX_CHANNELS < STRIDE) ? MAX_CHANNELS : STRIDE;
  localparam int PW     = $clog2(MAX_LAGS + 1);

  logic [3:0]       chan_cnt_r;
  logic [2:0]       lag_cnt_r;
  logic             use_icpt_r;
  logic [CNT_W-1:0] n_eff;
  logic [PW-1:0]    p_eff;
  dp_cmd_t          cmd;
  dp_status_t       status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= 4'd1;
      lag_cnt_r  <= 3'd1;
      use_icpt_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNELS: chan_cnt_r <= cfg_wdata[3:0];
        CFG_LAGS:     lag_cnt_r  <= cfg_wdata[2:0];
        CFG_ICPT:     use_icpt_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign n_eff = (chan_cnt_r == 4'd0)       ? CNT_W'(1) :
                 (32'(chan_cnt_r) > CH_LIM) ? CNT_W'(CH_LIM) : chan_cnt_r;
  assign p_eff = (lag_cnt_r == 3'd0)         ? PW'(1) :
                 (32'(lag_cnt_r) > MAX_LAGS) ? PW'(MAX_LAGS) : PW'(lag_cnt_r);

  vag_ctrl #(
    .MAX_LAGS (MAX_LAGS),
    .PW       (PW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .n_eff    (n_eff),
    .p_eff    (p_eff),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  vag_datapath #(
    .MAX_LAGS (MAX_LAGS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_data       (in_data),
    .use_intercept (use_icpt_r),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

`ifndef SYNTHESIS
  a_step_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_STEP) |=> in_stall)
    else $error("step beat did not start a computation");

  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation != OP_STEP) |=> !in_stall)
    else $error("load beat held the input");

  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_step |-> out_data.channel == CH_W'(n_eff - CNT_W'(1)))
    else $error("row end flagged on wrong channel");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result written over a waiting beat");
`endif

endmodule

`default_nettype wire
